// File: src/svs_pkg.sv
`timescale 1ns / 1ps

package svs_pkg;

   localparam int SAMPLE_W = 32;
   localparam int VOL_W    = 7;
   localparam int BASE_W   = 17;
   localparam int RG_W     = 19;
   localparam int PROD_W   = BASE_W + RG_W;
   localparam int CSR_AW   = 3;

   localparam logic [1:0] WMODE_16       = 2'd0;
   localparam logic [1:0] WMODE_24       = 2'd1;
   localparam logic [1:0] WMODE_32       = 2'd2;
   localparam logic [1:0] WMODE_RESERVED = 2'd3;

   localparam logic [CSR_AW-1:0] CSR_VOL_LEFT   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_VOL_RIGHT  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_REPLAY     = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_WIDTH_MODE = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_SWAP       = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_STEREO     = 3'd5;

   localparam logic [BASE_W-1:0]   UNITY_GAIN = 17'h10000;
   localparam logic [SAMPLE_W-1:0] HALF_UNITY = 32'd32768;
   localparam logic [VOL_W-1:0]    VOL_UNITY  = 7'd100;

   localparam logic [15:0] ATTEN_TABLE [100] = '{
      16'h0000, 16'h0110, 16'h011c, 16'h012f, 16'h013d, 16'h0152, 16'h0161, 16'h0179,
      16'h018a, 16'h01a5, 16'h01c1, 16'h01d5, 16'h01f5, 16'h020b, 16'h022e, 16'h0247,
      16'h026e, 16'h028a, 16'h02b6, 16'h02d5, 16'h0306, 16'h033a, 16'h035f, 16'h0399,
      16'h03c2, 16'h0403, 16'h0431, 16'h0479, 16'h04ac, 16'h04fd, 16'h0553, 16'h058f,
      16'h05ef, 16'h0633, 16'h069e, 16'h06ea, 16'h0761, 16'h07b5, 16'h083a, 16'h0898,
      16'h092c, 16'h09cb, 16'h0a3a, 16'h0aeb, 16'h0b67, 16'h0c2c, 16'h0cb6, 16'h0d92,
      16'h0e2d, 16'h0f21, 16'h1027, 16'h10de, 16'h1202, 16'h12cf, 16'h1414, 16'h14f8,
      16'h1662, 16'h1761, 16'h18f5, 16'h1a11, 16'h1bd3, 16'h1db4, 16'h1f06, 16'h211d,
      16'h2297, 16'h24ec, 16'h2690, 16'h292a, 16'h2aff, 16'h2de5, 16'h30fe, 16'h332b,
      16'h369f, 16'h390d, 16'h3ce6, 16'h3f9b, 16'h43e6, 16'h46eb, 16'h4bb3, 16'h4f11,
      16'h5466, 16'h5a18, 16'h5e19, 16'h6472, 16'h68ea, 16'h6ffd, 16'h74f8, 16'h7cdc,
      16'h826a, 16'h8b35, 16'h9499, 16'h9b35, 16'ha5ad, 16'had0b, 16'hb8b7, 16'hc0ee,
      16'hcdf1, 16'hd71a, 16'he59c, 16'hefd3
   };

   typedef struct packed {
      logic [VOL_W-1:0] vol_left;
      logic [VOL_W-1:0] vol_right;
      logic [RG_W-1:0]  replay_gain;
      logic [1:0]       width_mode;
      logic             swap_bytes;
      logic             stereo_stream;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] word;
      logic [1:0]          width_mode;
      logic                swap_bytes;
      logic                neg;
      logic                bypass;
   } meta_type;

   function automatic logic [BASE_W-1:0] base_gain(input logic [VOL_W-1:0] vol);
      if (vol >= VOL_UNITY) return UNITY_GAIN;
      return {1'b0, ATTEN_TABLE[vol]};
   endfunction

   function automatic logic [SAMPLE_W-1:0] width_mask(input logic [1:0] wmode);
      case (wmode)
         WMODE_16: return 32'h0000_ffff;
         WMODE_24: return 32'h00ff_ffff;
         default:  return 32'hffff_ffff;
      endcase
   endfunction

   // 2^(bits-1): magnitude of the negative limit
   function automatic logic [SAMPLE_W-1:0] sign_half(input logic [1:0] wmode);
      case (wmode)
         WMODE_16: return 32'h0000_8000;
         WMODE_24: return 32'h0080_0000;
         default:  return 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] swap_word(input logic [SAMPLE_W-1:0] v,
                                                     input logic [1:0] wmode);
      case (wmode)
         WMODE_16: return {16'd0, v[7:0], v[15:8]};
         WMODE_32: return {v[7:0], v[15:8], v[23:16], v[31:24]};
         default:  return v;
      endcase
   endfunction

endpackage

// File: src/stereo_soft_volume_scaler.sv
`timescale 1ns / 1ps
// Pipeline: four register stages (decode, gain, scale, encode); an accepted req word
// passes through each stage register in that order before rsp_tvalid rises.
// Throughput: one word per cycle sustained while rsp_tready is high; each stage
// holds one word and refills as soon as its word moves on, so bubbles close up under a stalled output.
// Reset (synchronous, active high) empties all stages and loads the register
// defaults: volume 100 on both channels, replay gain 1.0, 16-bit little endian, stereo.

module stereo_soft_volume_scaler import svs_pkg::*; #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,   // [31:0] sample_in
   input  logic                req_tuser,   // [0] channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,   // [31:0] sample_out
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [RG_W-1:0]     csr_wdata
);

   localparam int GAIN_W   = PROD_W - GAIN_FRAC_BITS;
   localparam int SCALED_W = GAIN_W + 16;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_VOL_LEFT:   cfg_in.vol_left      = csr_wdata[VOL_W-1:0];
            CSR_VOL_RIGHT:  cfg_in.vol_right     = csr_wdata[VOL_W-1:0];
            CSR_REPLAY:     cfg_in.replay_gain   = csr_wdata;
            CSR_WIDTH_MODE: cfg_in.width_mode    = csr_wdata[1:0];
            CSR_SWAP:       cfg_in.swap_bytes    = csr_wdata[0];
            CSR_STEREO:     cfg_in.stereo_stream = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vol_left      <= VOL_UNITY;
         cfg_ff.vol_right     <= VOL_UNITY;
         cfg_ff.replay_gain   <= RG_W'(UNITY_GAIN);
         cfg_ff.width_mode    <= WMODE_16;
         cfg_ff.swap_bytes    <= 1'b0;
         cfg_ff.stereo_stream <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic                d_valid, d_ready;
   meta_type            d_meta;
   logic [SAMPLE_W-1:0] d_mag;
   logic [BASE_W-1:0]   d_base;

   logic                g_valid, g_ready;
   meta_type            g_meta;
   logic [SAMPLE_W-1:0] g_mag;
   logic [GAIN_W-1:0]   g_gain;

   logic                s_valid, s_ready;
   meta_type            s_meta;
   logic [SCALED_W-1:0] s_scaled;

   svs_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (req_tdata),
      .in_channel (req_tuser),
      .out_valid  (d_valid),
      .out_ready  (d_ready),
      .out_meta   (d_meta),
      .out_mag    (d_mag),
      .out_base   (d_base)
   );

   svs_gain #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .GAIN_W         (GAIN_W)
   ) u_gain (
      .clock       (clock),
      .reset       (reset),
      .replay_gain (cfg_ff.replay_gain),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .in_meta     (d_meta),
      .in_mag      (d_mag),
      .in_base     (d_base),
      .out_valid   (g_valid),
      .out_ready   (g_ready),
      .out_meta    (g_meta),
      .out_mag     (g_mag),
      .out_gain    (g_gain)
   );

   svs_scale #(
      .GAIN_W   (GAIN_W),
      .SCALED_W (SCALED_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (g_valid),
      .in_ready   (g_ready),
      .in_meta    (g_meta),
      .in_mag     (g_mag),
      .in_gain    (g_gain),
      .out_valid  (s_valid),
      .out_ready  (s_ready),
      .out_meta   (s_meta),
      .out_scaled (s_scaled)
   );

   svs_encode #(
      .SCALED_W (SCALED_W)
   ) u_encode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s_valid),
      .in_ready   (s_ready),
      .in_meta    (s_meta),
      .in_scaled  (s_scaled),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_tdata)
   );

endmodule

// File: src/svs_decode.sv
`timescale 1ns / 1ps

module svs_decode import svs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_word,
   input  logic                in_channel,
   output logic                out_valid,
   input  logic                out_ready,
   output meta_type            out_meta,
   output logic [SAMPLE_W-1:0] out_mag,
   output logic [BASE_W-1:0]   out_base
);

   logic                valid_ff, valid_in;
   meta_type            meta_ff, meta_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [BASE_W-1:0]   base_ff, base_in;

   logic [SAMPLE_W-1:0] mask, raw;
   logic                neg;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      mask = width_mask(cfg.width_mode);
      raw  = in_word & mask;
      if (cfg.swap_bytes) raw = swap_word(raw, cfg.width_mode);
      neg  = (raw & sign_half(cfg.width_mode)) != '0;
   end

   always_comb begin
      valid_in = valid_ff;
      meta_in  = meta_ff;
      mag_in   = mag_ff;
      base_in  = base_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            meta_in.word       = in_word;
            meta_in.width_mode = cfg.width_mode;
            meta_in.swap_bytes = cfg.swap_bytes;
            meta_in.neg        = neg;
            meta_in.bypass     = !cfg.stereo_stream ||
                                 (cfg.width_mode == WMODE_RESERVED) ||
                                 ((cfg.width_mode == WMODE_24) && cfg.swap_bytes);
            mag_in  = neg ? ((~raw + 32'd1) & mask) : raw;
            base_in = base_gain(in_channel ? cfg.vol_right : cfg.vol_left);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      meta_ff <= meta_in;
      mag_ff  <= mag_in;
      base_ff <= base_in;
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_mag   = mag_ff;
   assign out_base  = base_ff;

endmodule

// File: src/svs_gain.sv
`timescale 1ns / 1ps

module svs_gain import svs_pkg::*; #(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int GAIN_W         = PROD_W - GAIN_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [RG_W-1:0]     replay_gain,
   input  logic                in_valid,
   output logic                in_ready,
   input  meta_type            in_meta,
   input  logic [SAMPLE_W-1:0] in_mag,
   input  logic [BASE_W-1:0]   in_base,
   output logic                out_valid,
   input  logic                out_ready,
   output meta_type            out_meta,
   output logic [SAMPLE_W-1:0] out_mag,
   output logic [GAIN_W-1:0]   out_gain
);

   logic                valid_ff, valid_in;
   meta_type            meta_ff, meta_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [PROD_W-1:0]   prod;

   assign in_ready = !valid_ff || out_ready;
   assign prod     = in_base * replay_gain;

   always_comb begin
      valid_in = valid_ff;
      meta_in  = meta_ff;
      mag_in   = mag_ff;
      gain_in  = gain_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            meta_in = in_meta;
            mag_in  = in_mag;
            gain_in = prod[PROD_W-1:GAIN_FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      meta_ff <= meta_in;
      mag_ff  <= mag_in;
      gain_ff <= gain_in;
   end

   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;
   assign out_mag   = mag_ff;
   assign out_gain  = gain_ff;

endmodule

// File: src/svs_scale.sv
`timescale 1ns / 1ps

module svs_scale import svs_pkg::*; #(
   parameter int GAIN_W   = 20,
   parameter int SCALED_W = GAIN_W + 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  meta_type            in_meta,
   input  logic [SAMPLE_W-1:0] in_mag,
   input  logic [GAIN_W-1:0]   in_gain,
   output logic                out_valid,
   input  logic                out_ready,
   output meta_type            out_meta,
   output logic [SCALED_W-1:0] out_scaled
);

   localparam int SUM_W = SAMPLE_W + GAIN_W;

   logic                valid_ff, valid_in;
   meta_type            meta_ff, meta_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [SUM_W-1:0]    sum;
   logic                unity;

   assign in_ready = !valid_ff || out_ready;
   // round half away from zero on the magnitude
   assign sum      = in_mag * in_gain + SUM_W'(HALF_UNITY);
   assign unity    = PROD_W'(in_gain) == PROD_W'(UNITY_GAIN);

   always_comb begin
      valid_in  = valid_ff;
      meta_in   = meta_ff;
      scaled_in = scaled_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            meta_in        = in_meta;
            meta_in.bypass = in_meta.bypass || unity;
            scaled_in      = sum[SUM_W-1:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      meta_ff   <= meta_in;
      scaled_ff <= scaled_in;
   end

   assign out_valid  = valid_ff;
   assign out_meta   = meta_ff;
   assign out_scaled = scaled_ff;

endmodule

// File: src/svs_encode.sv
`timescale 1ns / 1ps

module svs_encode import svs_pkg::*; #(
   parameter int SCALED_W = 36
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  meta_type            in_meta,
   input  logic [SCALED_W-1:0] in_scaled,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [SAMPLE_W-1:0] out_sample
);

   localparam int CMP_W = (SCALED_W > SAMPLE_W) ? SCALED_W : SAMPLE_W;

   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   logic [SAMPLE_W-1:0] mask, limit, sat, enc, result;
   logic                load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      mask  = width_mask(in_meta.width_mode);
      limit = in_meta.neg ? sign_half(in_meta.width_mode)
                          : sign_half(in_meta.width_mode) - 32'd1;
      if (CMP_W'(in_scaled) > CMP_W'(limit)) sat = limit;
      else sat = in_scaled[SAMPLE_W-1:0];
      enc = in_meta.neg ? ((~sat + 32'd1) & mask) : sat;
      if (in_meta.swap_bytes) enc = swap_word(enc, in_meta.width_mode);
      result = in_meta.bypass ? in_meta.word : ((in_meta.word & ~mask) | enc);
   end

   always_comb begin
      valid_in  = valid_ff;
      sample_in = sample_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) sample_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sample_ff <= sample_in;
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;

   a_bypass_copies: assert property (@(posedge clock) disable iff (reset)
      load && in_meta.bypass |=> sample_ff == $past(in_meta.word))
      else $error("bypassed word altered");

   a_upper_kept: assert property (@(posedge clock) disable iff (reset)
      load && !in_meta.bypass && (in_meta.width_mode == WMODE_16)
      |=> sample_ff[31:16] == $past(in_meta.word[31:16]))
      else $error("bits above the 16-bit format changed");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      load && !in_meta.bypass && !in_meta.neg && (in_scaled == '0) &&
      (in_meta.width_mode == WMODE_32) |=> sample_ff == '0)
      else $error("zero magnitude did not encode to zero");

endmodule
